// ===== design/lia_pkg.sv =====
package lia_pkg;

    // field widths
    localparam int X_W        = 16;
    localparam int ADDR_W     = 7;
    localparam int ENTRY_W    = 12;
    localparam int ACT_W      = 11;
    localparam int OFFSET_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // width of the interpolated result before clamping
    localparam int RES_W = 15;

    // number of entries covered by the reset curve
    localparam int CURVE_DEPTH = 1 << ADDR_W;

    // opcodes
    localparam logic OP_EVAL  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_OFFSET  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNSIGNED_MODE = 1'd1;

    // whole-unit bias that centers the curve on the table
    localparam int WHOLE_BIAS = 4;

    // clamp bounds in quarter units
    localparam logic signed [RES_W-1:0] UNS_LO = 15'sd0;
    localparam logic signed [RES_W-1:0] UNS_HI = 15'sd1020;
    localparam logic signed [RES_W-1:0] SGN_LO = -15'sd512;
    localparam logic signed [RES_W-1:0] SGN_HI = 15'sd508;

    // value of entries past the reset curve
    localparam logic signed [ENTRY_W-1:0] LAST_ENTRY = 12'sd1020;

    // gelu curve in quarter units
    localparam logic signed [ENTRY_W-1:0] GELU_Q [CURVE_DEPTH] = '{
        12'sd24,   12'sd24,   12'sd24,   12'sd24,   12'sd24,   12'sd24,   12'sd24,   12'sd24,
        12'sd23,   12'sd23,   12'sd23,   12'sd23,   12'sd22,   12'sd21,   12'sd21,   12'sd20,
        12'sd18,   12'sd17,   12'sd15,   12'sd13,   12'sd11,   12'sd9,    12'sd7,    12'sd6,
        12'sd4,    12'sd3,    12'sd3,    12'sd3,    12'sd5,    12'sd7,    12'sd11,   12'sd17,
        12'sd24,   12'sd33,   12'sd43,   12'sd54,   12'sd67,   12'sd81,   12'sd97,   12'sd113,
        12'sd129,  12'sd147,  12'sd164,  12'sd182,  12'sd199,  12'sd217,  12'sd235,  12'sd252,
        12'sd269,  12'sd286,  12'sd303,  12'sd319,  12'sd335,  12'sd352,  12'sd368,  12'sd384,
        12'sd400,  12'sd415,  12'sd431,  12'sd447,  12'sd463,  12'sd478,  12'sd494,  12'sd510,
        12'sd525,  12'sd541,  12'sd557,  12'sd572,  12'sd588,  12'sd604,  12'sd619,  12'sd635,
        12'sd651,  12'sd666,  12'sd682,  12'sd698,  12'sd713,  12'sd729,  12'sd745,  12'sd760,
        12'sd776,  12'sd792,  12'sd807,  12'sd823,  12'sd839,  12'sd854,  12'sd870,  12'sd886,
        12'sd901,  12'sd917,  12'sd933,  12'sd948,  12'sd964,  12'sd980,  12'sd995,  12'sd1011,
        12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020,
        12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020,
        12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020,
        12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020, 12'sd1020
    };

    // table write request
    typedef struct packed {
        logic                      en;
        logic [ADDR_W-1:0]         addr;
        logic signed [ENTRY_W-1:0] data;
    } tbl_wr_t;

    function automatic logic signed [ENTRY_W-1:0] gelu_entry(input logic [ADDR_W-1:0] a);
        return GELU_Q[a];
    endfunction

endpackage

// ===== design/lia_table.sv =====
module lia_table #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lia_pkg::tbl_wr_t                  wr,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    rd_a_addr,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    rd_b_addr,
    output logic signed [lia_pkg::ENTRY_W-1:0] rd_a_data,
    output logic signed [lia_pkg::ENTRY_W-1:0] rd_b_data
);
    import lia_pkg::*;

    // only the low entries are writable; higher ones hold the last curve value
    localparam int MEM_DEPTH = (TABLE_DEPTH < CURVE_DEPTH) ? TABLE_DEPTH : CURVE_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    logic signed [ENTRY_W-1:0] mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]      valid_reg;

    logic                      wr_hit;
    logic [MEM_AW-1:0]         wr_idx;
    logic [MEM_AW-1:0]         a_idx;
    logic [MEM_AW-1:0]         b_idx;
    logic                      a_in_mem;
    logic                      b_in_mem;
    logic signed [ENTRY_W-1:0] a_dflt_next;
    logic signed [ENTRY_W-1:0] b_dflt_next;

    logic                      a_use_mem_reg;
    logic                      b_use_mem_reg;
    logic signed [ENTRY_W-1:0] a_mem_reg;
    logic signed [ENTRY_W-1:0] b_mem_reg;
    logic signed [ENTRY_W-1:0] a_dflt_reg;
    logic signed [ENTRY_W-1:0] b_dflt_reg;

    // address decode
    assign wr_hit   = wr.en && (int'(wr.addr) < MEM_DEPTH);
    assign wr_idx   = wr.addr[MEM_AW-1:0];
    assign a_idx    = rd_a_addr[MEM_AW-1:0];
    assign b_idx    = rd_b_addr[MEM_AW-1:0];
    assign a_in_mem = int'(rd_a_addr) < MEM_DEPTH;
    assign b_in_mem = int'(rd_b_addr) < MEM_DEPTH;

    // reset contents for entries not yet written
    assign a_dflt_next = a_in_mem ? gelu_entry(ADDR_W'(a_idx)) : LAST_ENTRY;
    assign b_dflt_next = b_in_mem ? gelu_entry(ADDR_W'(b_idx)) : LAST_ENTRY;

    // written-entry flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            a_use_mem_reg <= 1'b0;
            b_use_mem_reg <= 1'b0;
        end
        else
        begin
            a_use_mem_reg <= a_in_mem && valid_reg[a_idx];
            b_use_mem_reg <= b_in_mem && valid_reg[b_idx];
            if (wr_hit)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // table storage, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[wr_idx] <= wr.data;
        end
        a_mem_reg  <= mem[a_idx];
        b_mem_reg  <= mem[b_idx];
        a_dflt_reg <= a_dflt_next;
        b_dflt_reg <= b_dflt_next;
    end

    assign rd_a_data = a_use_mem_reg ? a_mem_reg : a_dflt_reg;
    assign rd_b_data = b_use_mem_reg ? b_mem_reg : b_dflt_reg;

endmodule

// ===== design/lut_interp_activation_unit.sv =====
// Table-based activation unit (GELU curve at reset) with linear interpolation
// between neighboring entries. One word is taken on every cycle in which start
// is high; busy is always low, so the block never holds the sender off. An
// evaluate word gives one result on done, in the order the words came in; the
// four register stages are index computation, table read, difference times
// fraction, and shift/add/clamp. The receiver cannot stall, so the result is
// shown for exactly the one done cycle. A table write word gives no result; it
// updates the entry at the edge it is taken, and every evaluate word taken
// later sees the new value.
module lut_interp_activation_unit #(
    parameter int TABLE_DEPTH     = 128,
    parameter int INPUT_FRAC_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [lia_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lia_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 opcode,
    input  logic signed [lia_pkg::X_W-1:0]       x_value,
    input  logic [lia_pkg::ADDR_W-1:0]           table_addr,
    input  logic signed [lia_pkg::ENTRY_W-1:0]   table_value,
    output logic                                 done,
    output logic signed [lia_pkg::ACT_W-1:0]     act_value,
    output logic                                 saturated
);
    import lia_pkg::*;

    localparam int IW     = $clog2(TABLE_DEPTH);
    localparam int MU_W   = INPUT_FRAC_BITS - 3;
    localparam int SUM_W  = X_W + 8;
    localparam int IDXF_W = SUM_W - MU_W;
    localparam int DIFF_W = ENTRY_W + 1;
    localparam int PROD_W = MU_W + 1 + DIFF_W;

    localparam logic [IW-1:0]           LAST_IDX = IW'(TABLE_DEPTH - 1);
    localparam logic [IDXF_W-1:0]       MAX_IDX  = IDXF_W'(TABLE_DEPTH - 1);
    localparam logic signed [SUM_W-1:0] BIAS     = SUM_W'(WHOLE_BIAS) <<< INPUT_FRAC_BITS;

    // configuration
    logic signed [OFFSET_W-1:0] input_offset_reg;
    logic                       unsigned_mode_reg;

    // handshake
    logic    accept;
    tbl_wr_t tbl_wr;

    // stage 1 logic
    logic signed [SUM_W-1:0] x_ext;
    logic signed [SUM_W-1:0] off_ext;
    logic signed [SUM_W-1:0] sum;
    logic [IDXF_W-1:0]       idx_full;
    logic [IW-1:0]           idx_next;
    logic [IW-1:0]           nidx_next;
    logic [MU_W-1:0]         frac_next;
    logic                    sat_next;

    // stage 1 registers
    logic            s1_valid_reg;
    logic [IW-1:0]   s1_idx_reg;
    logic [IW-1:0]   s1_nidx_reg;
    logic [MU_W-1:0] s1_frac_reg;
    logic            s1_sat_reg;

    // stage 2 registers (table data comes registered from the table)
    logic                      s2_valid_reg;
    logic [MU_W-1:0]           s2_frac_reg;
    logic                      s2_sat_reg;
    logic signed [ENTRY_W-1:0] s2_e;
    logic signed [ENTRY_W-1:0] s2_n;

    // stage 3 logic and registers
    logic signed [DIFF_W-1:0]  diff;
    logic signed [MU_W:0]      frac_s;
    logic signed [PROD_W-1:0]  prod_next;
    logic                      s3_valid_reg;
    logic                      s3_sat_reg;
    logic signed [ENTRY_W-1:0] s3_e_reg;
    logic signed [PROD_W-1:0]  s3_prod_reg;

    // stage 4 logic and output registers
    logic signed [PROD_W-1:0] quot;
    logic signed [RES_W-1:0]  res;
    logic signed [RES_W-1:0]  lo;
    logic signed [RES_W-1:0]  hi;
    logic signed [RES_W-1:0]  res_clamped;
    logic                     res_sat;
    logic                     done_reg;
    logic signed [ACT_W-1:0]  act_value_reg;
    logic                     saturated_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_offset_reg  <= '0;
            unsigned_mode_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_INPUT_OFFSET:  input_offset_reg  <= cfg_data[OFFSET_W-1:0];
                CFG_UNSIGNED_MODE: unsigned_mode_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // table write request
    always_comb
    begin
        tbl_wr.en   = accept && (opcode == OP_WRITE);
        tbl_wr.addr = table_addr;
        tbl_wr.data = table_value;
    end

    // offset, bias and split into index and fraction
    assign x_ext    = SUM_W'(x_value);
    assign off_ext  = SUM_W'(input_offset_reg);
    assign sum      = x_ext + (off_ext <<< INPUT_FRAC_BITS) + BIAS;
    assign idx_full = sum[SUM_W-1:MU_W];

    always_comb
    begin
        if (sum[SUM_W-1])
        begin
            idx_next  = '0;
            frac_next = '0;
            sat_next  = 1'b1;
        end
        else if (idx_full > MAX_IDX)
        begin
            idx_next  = LAST_IDX;
            frac_next = '0;
            sat_next  = 1'b1;
        end
        else
        begin
            idx_next  = idx_full[IW-1:0];
            frac_next = sum[MU_W-1:0];
            sat_next  = 1'b0;
        end
        nidx_next = (idx_next == LAST_IDX) ? idx_next : IW'(idx_next + 1'b1);
    end

    lia_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (tbl_wr),
        .rd_a_addr (s1_idx_reg),
        .rd_b_addr (s1_nidx_reg),
        .rd_a_data (s2_e),
        .rd_b_data (s2_n)
    );

    // difference times fraction
    assign diff      = DIFF_W'(s2_n) - DIFF_W'(s2_e);
    assign frac_s    = signed'({1'b0, s2_frac_reg});
    assign prod_next = frac_s * diff;

    // floor in whole units, back to quarters, then clamp
    assign quot = s3_prod_reg >>> (MU_W + 2);
    assign res  = RES_W'(s3_e_reg) + (RES_W'(quot) <<< 2);
    assign lo   = unsigned_mode_reg ? UNS_LO : SGN_LO;
    assign hi   = unsigned_mode_reg ? UNS_HI : SGN_HI;

    always_comb
    begin
        if (res > hi)
        begin
            res_clamped = hi;
            res_sat     = 1'b1;
        end
        else if (res < lo)
        begin
            res_clamped = lo;
            res_sat     = 1'b1;
        end
        else
        begin
            res_clamped = res;
            res_sat     = 1'b0;
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && (opcode == OP_EVAL);
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    // pipeline data
    always_ff @(posedge clk)
    begin
        s1_idx_reg    <= idx_next;
        s1_nidx_reg   <= nidx_next;
        s1_frac_reg   <= frac_next;
        s1_sat_reg    <= sat_next;
        s2_frac_reg   <= s1_frac_reg;
        s2_sat_reg    <= s1_sat_reg;
        s3_e_reg      <= s2_e;
        s3_prod_reg   <= prod_next;
        s3_sat_reg    <= s2_sat_reg;
        act_value_reg <= ACT_W'(res_clamped);
        saturated_reg <= s3_sat_reg || res_sat;
    end

    assign done      = done_reg;
    assign act_value = act_value_reg;
    assign saturated = saturated_reg;

endmodule

// ===== dv/lut_interp_activation_checker.sv =====
`timescale 1ns / 1ps

module lut_interp_activation_checker
    import lia_pkg::*;
#(
    parameter int TABLE_DEPTH     = 128,
    parameter int INPUT_FRAC_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      start,
    input  logic                      busy,
    input  logic                      opcode,
    input  logic signed [X_W-1:0]     x_value,
    input  logic [ADDR_W-1:0]         table_addr,
    input  logic signed [ENTRY_W-1:0] table_value,
    input  logic                      done,
    input  logic signed [ACT_W-1:0]   act_value,
    input  logic                      saturated,
    output int                        fail_count,
    output int                        pending_count
);

    // bits of the input below one table step
    localparam int STEP_BITS = INPUT_FRAC_BITS - 3;

    typedef struct packed {
        logic signed [ACT_W-1:0] act;
        logic                    sat;
    } act_word_t;

    // shadow copy of the curve and the registers
    logic signed [ENTRY_W-1:0] curve [TABLE_DEPTH];
    int                        offset_reg;
    logic                      unsigned_clamp;
    act_word_t                 expected_acts [$];

    // interpolate one sample against the shadow curve
    function automatic act_word_t predict_activation(input logic signed [X_W-1:0] x);
        int        sum;
        int        idx;
        int        nxt;
        int        frac;
        int        e;
        int        n;
        int        r;
        int        lo;
        int        hi;
        logic      sat;
        act_word_t w;
        sat = 1'b0;
        sum = int'(x) + (offset_reg + WHOLE_BIAS) * (1 << INPUT_FRAC_BITS);
        if (sum < 0)
        begin
            idx  = 0;
            frac = 0;
            sat  = 1'b1;
        end
        else
        begin
            idx  = sum >> STEP_BITS;
            frac = sum & ((1 << STEP_BITS) - 1);
            if (idx > TABLE_DEPTH - 1)
            begin
                idx  = TABLE_DEPTH - 1;
                frac = 0;
                sat  = 1'b1;
            end
        end
        // last entry interpolates against itself
        nxt = (idx + 1 > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : idx + 1;
        e   = curve[idx];
        n   = curve[nxt];
        // floor in whole units, i.e. four quarter units
        r   = e + 4 * ((frac * (n - e)) >>> (STEP_BITS + 2));
        if (unsigned_clamp)
        begin
            lo = int'(UNS_LO);
            hi = int'(UNS_HI);
        end
        else
        begin
            lo = int'(SGN_LO);
            hi = int'(SGN_HI);
        end
        if (r > hi)
        begin
            r   = hi;
            sat = 1'b1;
        end
        else if (r < lo)
        begin
            r   = lo;
            sat = 1'b1;
        end
        w.act = r[ACT_W-1:0];
        w.sat = sat;
        return w;
    endfunction

    // watch config, input words and results
    always @(posedge clk or negedge rst_n)
    begin
        act_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                curve[i] = (i < CURVE_DEPTH) ? GELU_Q[i] : LAST_ENTRY;
            offset_reg     = 0;
            unsigned_clamp = 1'b1;
            expected_acts.delete();
            fail_count     = 0;
            pending_count  = 0;
        end
        else
        begin
            // compare the result word with the oldest prediction
            if (done)
            begin
                if (expected_acts.size() == 0)
                begin
                    $error("result word with nothing expected: act_value %0d saturated %0b",
                           act_value, saturated);
                    fail_count++;
                end
                else
                begin
                    want = expected_acts.pop_front();
                    if (act_value !== want.act)
                    begin
                        $error("act_value: expected %0d, actual %0d", want.act, act_value);
                        fail_count++;
                    end
                    if (saturated !== want.sat)
                    begin
                        $error("saturated: expected %0b, actual %0b", want.sat, saturated);
                        fail_count++;
                    end
                end
            end
            // register writes
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_INPUT_OFFSET)
                    offset_reg = int'($signed(cfg_data[OFFSET_W-1:0]));
                else if (cfg_index == CFG_UNSIGNED_MODE)
                    unsigned_clamp = cfg_data[0];
            end
            // accepted input word
            if (start && !busy)
            begin
                if (opcode == OP_EVAL)
                    expected_acts.push_back(predict_activation(x_value));
                else if (int'(table_addr) < TABLE_DEPTH)
                    curve[table_addr] = table_value;
            end
            pending_count = expected_acts.size();
        end
    end

endmodule

// ===== dv/lut_interp_activation_unit_tb.sv =====
`timescale 1ns / 1ps

module lut_interp_activation_unit_tb;
    import lia_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_PAUSE = 8;
    localparam int PHASE_WORDS = 250;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index   = '0;
    logic [CFG_DATA_W-1:0]     cfg_data    = '0;
    logic                      start       = 1'b0;
    logic                      busy;
    logic                      opcode      = OP_EVAL;
    logic signed [X_W-1:0]     x_value     = '0;
    logic [ADDR_W-1:0]         table_addr  = '0;
    logic signed [ENTRY_W-1:0] table_value = '0;
    logic                      done;
    logic signed [ACT_W-1:0]   act_value;
    logic                      saturated;

    int fail_count;
    int pending_count;
    int stall_cycles = 0;
    bit idle_enable  = 1'b1;
    int cur_offset   = 0;

    lut_interp_activation_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .x_value     (x_value),
        .table_addr  (table_addr),
        .table_value (table_value),
        .done        (done),
        .act_value   (act_value),
        .saturated   (saturated)
    );

    lut_interp_activation_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .x_value       (x_value),
        .table_addr    (table_addr),
        .table_value   (table_value),
        .done          (done),
        .act_value     (act_value),
        .saturated     (saturated),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // present one word, with random idle cycles ahead of it
    task automatic send_word(input logic op, input int x, input int addr, input int val);
        while (idle_enable && $urandom_range(0, 99) < 19)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        opcode      <= op;
        x_value     <= x[X_W-1:0];
        table_addr  <= addr[ADDR_W-1:0];
        table_value <= val[ENTRY_W-1:0];
        do
            @(posedge clk);
        while (busy);
    endtask

    // stop sending, let every result come out and the pipe empty
    task automatic drain_pipe();
        start <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // write both registers while idle
    task automatic set_config(input int offs, input logic mode);
        logic [CFG_DATA_W-2:0] junk;
        junk       = (CFG_DATA_W-1)'($urandom);
        cur_offset = offs;
        cfg_wr_en  <= 1'b1;
        cfg_index  <= CFG_INPUT_OFFSET;
        cfg_data   <= offs[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index  <= CFG_UNSIGNED_MODE;
        cfg_data   <= {junk, mode};
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
    endtask

    // mostly evaluations aimed at the table, some table rewrites
    task automatic run_random(input int count);
        int x;
        int val;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                case ($urandom_range(0, 3))
                    0: val = $urandom;
                    1: val = $urandom_range(0, 1) ? -2048 : 2047;
                    default: val = $urandom_range(0, 1020);
                endcase
                send_word(OP_WRITE, $urandom, $urandom, val);
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0, 1:
                    begin
                        x = $urandom_range(0, 66559) - 512 - (cur_offset + WHOLE_BIAS) * 4096;
                        if (x < -32768 || x > 32767)
                            x = $urandom;
                    end
                    2:
                    begin
                        // near a step boundary
                        x = $urandom_range(0, 128) * 512 - ($urandom_range(0, 1) ? 0 : 1)
                            - (cur_offset + WHOLE_BIAS) * 4096;
                        if (x < -32768 || x > 32767)
                            x = $urandom;
                    end
                    3:
                    begin
                        case ($urandom_range(0, 3))
                            0: x = -32768;
                            1: x = 32767;
                            2: x = 0;
                            default: x = -1;
                        endcase
                    end
                    default: x = $urandom;
                endcase
                send_word(OP_EVAL, x, $urandom, $urandom);
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: offset 0, unsigned clamp
        send_word(OP_EVAL, -32768, 0, 0);
        send_word(OP_EVAL, 32767, 127, -1);
        send_word(OP_EVAL, 0, 0, 0);
        send_word(OP_EVAL, -1, 0, 0);
        send_word(OP_EVAL, -16384, 0, 0);
        send_word(OP_EVAL, -16385, 0, 0);
        send_word(OP_EVAL, 21845, 0, 0);
        send_word(OP_EVAL, -21846, 0, 0);
        // extreme entries force both clamps
        send_word(OP_WRITE, 0, 0, -2048);
        send_word(OP_WRITE, 0, 1, 2047);
        send_word(OP_EVAL, -16384, 0, 0);
        send_word(OP_EVAL, -16384 + 256, 0, 0);
        send_word(OP_EVAL, -16384 + 511, 0, 0);
        send_word(OP_WRITE, 0, 127, 2047);
        send_word(OP_WRITE, 0, 126, -2048);

        // top of the table, signed clamp
        drain_pipe();
        set_config(8, 1'b0);
        send_word(OP_EVAL, 16383, 0, 0);
        send_word(OP_EVAL, 16384, 0, 0);
        send_word(OP_EVAL, 15871, 0, 0);
        send_word(OP_EVAL, 15360, 0, 0);
        send_word(OP_EVAL, 32767, 0, 0);

        // bottom of the table
        drain_pipe();
        set_config(-8, 1'b1);
        send_word(OP_EVAL, 32767, 0, 0);
        send_word(OP_EVAL, -32768, 0, 0);
        send_word(OP_EVAL, 16384, 0, 0);
        send_word(OP_EVAL, 16383, 0, 0);

        // random phases over several settings
        drain_pipe();
        set_config(-8, 1'b0);
        run_random(PHASE_WORDS);
        drain_pipe();
        set_config(8, 1'b1);
        run_random(PHASE_WORDS);
        drain_pipe();
        set_config($urandom_range(0, 16) - 8, 1'b0);
        run_random(PHASE_WORDS);
        // back to back, no idle cycles
        drain_pipe();
        idle_enable = 1'b0;
        set_config($urandom_range(0, 16) - 8, 1'b1);
        run_random(PHASE_WORDS);
        drain_pipe();
        idle_enable = 1'b1;
        set_config(8, 1'b0);
        run_random(PHASE_WORDS);
        drain_pipe();
        set_config(-8, 1'b1);
        run_random(PHASE_WORDS);

        drain_pipe();
        @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
